@@ sv/rrw_pkg.sv @@
// Shared types and constants for the reliable receive reorder window.
// No dependencies; rrw_classify and reliable_receive_reorder_window import it.
package rrw_pkg;

  // Sequence numbers run modulo this value; the all-ones pattern is never a number.
  localparam logic [15:0] SEQ_MOD  = 16'hFFFF;
  localparam logic [15:0] SEQ_LAST = 16'hFFFE;

  localparam logic [1:0] KIND_ACK     = 2'd0;
  localparam logic [1:0] KIND_DUP     = 2'd1;
  localparam logic [1:0] KIND_REJECT  = 2'd2;
  localparam logic [1:0] KIND_DELIVER = 2'd3;

  typedef struct packed {
    logic [15:0] seq_number;
    logic        msg_type;
    logic [15:0] payload_tag;
  } packet_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [15:0] out_number;
    logic        out_type;
    logic [15:0] out_tag;
    logic        last;
  } result_t;

  typedef struct packed {
    logic in_window;
    logic duplicate;
    logic deliver_now;
  } class_t;

endpackage

@@ sv/rrw_slot_mem.sv @@
// Reorder slot storage: one entry per slot holding the packet type and payload tag.
// Synchronous write, registered read. Uses no package items.
module rrw_slot_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 17,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/rrw_classify.sv @@
// Classifies an arriving sequence number against the expected number and window,
// and computes its reorder slot. Depends on rrw_pkg.
module rrw_classify #(
  parameter int WINDOW_MAX = 16,
  parameter int IW         = 4
) (
  input  logic [15:0]       seq_number,
  input  logic [15:0]       expected,
  input  logic [4:0]        window_size,
  input  logic [IW-1:0]     head,
  output rrw_pkg::class_t   cls,
  output logic [IW-1:0]     slot
);
  import rrw_pkg::*;

  localparam logic [15:0] WMAX16 = 16'(WINDOW_MAX);
  localparam logic [IW:0] WMAXS  = (IW+1)'(WINDOW_MAX);

  logic [15:0] win;
  logic [16:0] diff;
  logic [15:0] offset;
  logic        number_ok;
  logic [IW:0] slot_sum;

  always_comb begin
    if (window_size == 5'd0) begin
      win = 16'd1;
    end else if (16'(window_size) > WMAX16) begin
      win = WMAX16;
    end else begin
      win = 16'(window_size);
    end

    // A negative difference wraps by 65535, which is one less than the 16-bit wrap.
    diff   = {1'b0, seq_number} - {1'b0, expected};
    offset = diff[16] ? (diff[15:0] - 16'd1) : diff[15:0];

    number_ok       = (seq_number != SEQ_MOD);
    cls.in_window   = number_ok && (offset < win);
    cls.duplicate   = number_ok && !cls.in_window && (offset >= (SEQ_MOD - win));
    cls.deliver_now = cls.in_window && (offset == 16'd0);

    slot_sum = {1'b0, head} + offset[IW:0];
    slot     = (slot_sum >= WMAXS) ? IW'(slot_sum - WMAXS) : IW'(slot_sum);
  end

endmodule

@@ sv/reliable_receive_reorder_window.sv @@
// Receive side of a selective-repeat channel. An item is taken when start is high and busy
// is low. A packet that is not the expected one gives one result. The expected packet gives
// an ack, its own delivery and one delivery per held packet that follows it in order, since
// the slot RAM is read one entry per cycle with the next read issued while the current
// entry is emitted. Each result is registered and appears on result for one cycle with
// strobe high; the receiver cannot hold results off, and last marks an item's final
// result. Slot valid bits are flip-flops cleared by reset, so no clearing pass is needed.
// Depends on rrw_pkg, rrw_classify and rrw_slot_mem.
module reliable_receive_reorder_window #(
  parameter int WINDOW_MAX = 16,
  parameter int TAG_BITS   = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  rrw_pkg::packet_t packet,
  input  logic             cfg_we,
  input  logic [4:0]       cfg_wdata,
  output logic             strobe,
  output rrw_pkg::result_t result
);
  import rrw_pkg::*;

  localparam int IW = $clog2(WINDOW_MAX);
  localparam int TB = (TAG_BITS < 16) ? TAG_BITS : 16;
  localparam logic [IW-1:0] HEAD_TOP = IW'(WINDOW_MAX - 1);
  localparam logic [IW:0]   CNT_STOP = (IW+1)'(WINDOW_MAX - 2);

  typedef enum logic [1:0] {S_IDLE, S_CLASS, S_DELIV, S_REL} state_t;

  state_t            state;
  logic [4:0]        window_size;
  logic [15:0]       expected;
  logic [IW-1:0]     head;
  logic [WINDOW_MAX-1:0] slot_valid;
  packet_t           pkt;
  logic [IW-1:0]     cnt;

  class_t            cls;
  logic [IW-1:0]     slot;
  logic [IW-1:0]     head_next;
  logic [15:0]       expected_next;
  logic              mem_we;
  logic [TB:0]       mem_wdata;
  logic [TB:0]       mem_rdata;
  logic              more_rel;

  rrw_classify #(.WINDOW_MAX(WINDOW_MAX), .IW(IW)) u_classify (
    .seq_number (pkt.seq_number),
    .expected   (expected),
    .window_size(window_size),
    .head       (head),
    .cls        (cls),
    .slot       (slot)
  );

  // The read address is always the slot after the head, so the entry at the new head
  // is ready as soon as the head advances.
  rrw_slot_mem #(.DEPTH(WINDOW_MAX), .WIDTH(TB + 1), .AW(IW)) u_slot_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(slot),
    .wdata(mem_wdata),
    .raddr(head_next),
    .rdata(mem_rdata)
  );

  always_comb begin
    head_next     = (head == HEAD_TOP) ? '0 : head + 1'b1;
    expected_next = (expected == SEQ_LAST) ? 16'd0 : expected + 16'd1;
    mem_we        = (state == S_CLASS) && cls.in_window && !cls.deliver_now &&
                    !slot_valid[slot];
    mem_wdata     = {pkt.msg_type, pkt.payload_tag[TB-1:0]};
    more_rel      = slot_valid[head_next] && ({1'b0, cnt} < CNT_STOP);
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      window_size <= 5'd10;
      expected    <= 16'd0;
      head        <= '0;
      slot_valid  <= '0;
      strobe      <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_size <= cfg_wdata;
      end
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            pkt   <= packet;
            state <= S_CLASS;
          end
        end
        S_CLASS: begin
          strobe             <= 1'b1;
          result.out_type    <= 1'b0;
          result.out_tag     <= 16'd0;
          if (cls.in_window) begin
            result.result_kind <= KIND_ACK;
            result.out_number  <= pkt.seq_number;
            result.last        <= !cls.deliver_now;
            if (mem_we) begin
              slot_valid[slot] <= 1'b1;
            end
            state <= cls.deliver_now ? S_DELIV : S_IDLE;
          end else if (cls.duplicate) begin
            result.result_kind <= KIND_DUP;
            result.out_number  <= pkt.seq_number;
            result.last        <= 1'b1;
            state              <= S_IDLE;
          end else begin
            result.result_kind <= KIND_REJECT;
            result.out_number  <= 16'd0;
            result.last        <= 1'b1;
            state              <= S_IDLE;
          end
        end
        S_DELIV: begin
          strobe             <= 1'b1;
          result.result_kind <= KIND_DELIVER;
          result.out_number  <= pkt.seq_number;
          result.out_type    <= pkt.msg_type;
          result.out_tag     <= 16'(pkt.payload_tag[TB-1:0]);
          result.last        <= !slot_valid[head_next];
          slot_valid[head]   <= 1'b0;
          head               <= head_next;
          expected           <= expected_next;
          cnt                <= '0;
          state              <= slot_valid[head_next] ? S_REL : S_IDLE;
        end
        S_REL: begin
          strobe             <= 1'b1;
          result.result_kind <= KIND_DELIVER;
          result.out_number  <= expected;
          result.out_type    <= mem_rdata[TB];
          result.out_tag     <= 16'(mem_rdata[TB-1:0]);
          result.last        <= !more_rel;
          slot_valid[head]   <= 1'b0;
          head               <= head_next;
          expected           <= expected_next;
          cnt                <= cnt + 1'b1;
          state              <= more_rel ? S_REL : S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // More results of the same item always follow while the block is still busy.
  a_busy_until_last: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last |-> busy)
    else $error("result without last while block is idle");

  // A delivery that is not the last is followed at once by another delivery.
  a_release_burst: assert property (@(posedge clk) disable iff (rst)
    strobe && (result.result_kind == KIND_DELIVER) && !result.last |=>
    strobe && (result.result_kind == KIND_DELIVER))
    else $error("gap in release burst");

  // Between items the head slot is never occupied.
  a_head_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !slot_valid[head])
    else $error("head slot valid while idle");

  a_expected_range: assert property (@(posedge clk) disable iff (rst)
    expected != SEQ_MOD)
    else $error("expected number out of range");

endmodule

@@ tb/sv/tb_reliable_receive_reorder_window.sv @@
// Self-checking testbench for reliable_receive_reorder_window.
// A directed table is followed by random in-window bursts and noise. Depends on rrw_pkg
// and the RTL under sv/. Typed rows are checked against their table result, the rest against a behavioral predictor.
module tb_reliable_receive_reorder_window;
  timeunit 1ns;
  timeprecision 1ps;
  import rrw_pkg::*;

  localparam int WIN_MAX     = 16;
  localparam int QUIET_LIMIT = 1000;
  localparam int ITEM_TARGET = 370;

  typedef struct packed {
    bit          is_cfg;
    logic [4:0]  win;
    packet_t     pkt;
    bit          typed;
    logic [1:0]  kind;
    logic [15:0] num;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        cfg_we = 1'b0;
  logic [4:0]  cfg_wdata = 5'd0;
  packet_t     packet = '0;
  logic        busy;
  logic        strobe;
  result_t     result;

  // Predicted receiver state.
  logic [4:0]  win_reg = 5'd10;
  logic [15:0] exp_num = 16'd0;
  logic [3:0]  head = 4'd0;
  bit          slot_full [WIN_MAX];
  logic [15:0] slot_tag [WIN_MAX];
  logic        slot_type [WIN_MAX];

  result_t     batch [0:WIN_MAX];
  int          batch_n;
  result_t     pending_results [$];
  bit          typed_row = 1'b0;
  result_t     typed_res = '0;
  stim_row_t   directed [0:24];
  int          n_errors = 0;
  int          quiet_cycles = 0;
  int          n_sent = 0;
  int          idle_pct = 12;

  always #4 clk = ~clk;

  reliable_receive_reorder_window #(
    .WINDOW_MAX(WIN_MAX),
    .TAG_BITS  (16)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .packet   (packet),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .strobe   (strobe),
    .result   (result)
  );

  function automatic int eff_window(logic [4:0] v);
    if (v == 5'd0) return 1;
    if (int'(v) > WIN_MAX) return WIN_MAX;
    return int'(v);
  endfunction

  function automatic result_t mk_result(logic [1:0] kind, logic [15:0] num, logic t,
                                        logic [15:0] tag);
    result_t r;
    r.result_kind = kind;
    r.out_number  = num;
    r.out_type    = t;
    r.out_tag     = tag;
    r.last        = 1'b0;
    return r;
  endfunction

  function automatic stim_row_t pkt_row(logic [15:0] seq, logic t, logic [15:0] tag, bit typed,
                                        logic [1:0] kind, logic [15:0] num);
    stim_row_t r;
    r.is_cfg = 1'b0;
    r.win    = 5'd0;
    r.pkt.seq_number  = seq;
    r.pkt.msg_type    = t;
    r.pkt.payload_tag = tag;
    r.typed  = typed;
    r.kind   = kind;
    r.num    = num;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [4:0] v);
    stim_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.win    = v;
    return r;
  endfunction

  task automatic move_on();
    exp_num = (exp_num == SEQ_LAST) ? 16'd0 : exp_num + 16'd1;
    head    = head + 4'd1;
  endtask

  // Works out the results of one accepted packet into batch and updates the window.
  task automatic reorder_receive(input packet_t p);
    int w;
    int d;
    int s;
    int i;
    batch_n = 0;
    w = eff_window(win_reg);
    if (p.seq_number == SEQ_MOD) begin
      batch[batch_n++] = mk_result(KIND_REJECT, 16'd0, 1'b0, 16'd0);
    end else begin
      d = (int'(p.seq_number) + int'(SEQ_MOD) - int'(exp_num)) % int'(SEQ_MOD);
      if (d < w) begin
        batch[batch_n++] = mk_result(KIND_ACK, p.seq_number, 1'b0, 16'd0);
        if (d == 0) begin
          batch[batch_n++] = mk_result(KIND_DELIVER, p.seq_number, p.msg_type, p.payload_tag);
          slot_full[head] = 1'b0;
          move_on();
          // At most WIN_MAX - 1 packets can be held behind the one just delivered.
          for (i = 0; i < WIN_MAX - 1 && slot_full[head]; i++) begin
            batch[batch_n++] = mk_result(KIND_DELIVER, exp_num, slot_type[head], slot_tag[head]);
            slot_full[head] = 1'b0;
            move_on();
          end
        end else begin
          s = (int'(head) + d) % WIN_MAX;
          if (!slot_full[s]) begin
            slot_full[s] = 1'b1;
            slot_tag[s]  = p.payload_tag;
            slot_type[s] = p.msg_type;
          end
        end
      end else if (d >= int'(SEQ_MOD) - w) begin
        batch[batch_n++] = mk_result(KIND_DUP, p.seq_number, 1'b0, 16'd0);
      end else begin
        batch[batch_n++] = mk_result(KIND_REJECT, 16'd0, 1'b0, 16'd0);
      end
    end
    batch[batch_n - 1].last = 1'b1;
  endtask

  task automatic report(input string field, input logic [15:0] got, input logic [15:0] want);
    $display("mismatch in %s: got 0x%0h, expected 0x%0h", field, got, want);
    n_errors++;
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (pending_results.size() == 0) begin
      report("unexpected result, number", got.out_number, 16'd0);
    end else begin
      want = pending_results.pop_front();
      if (got.result_kind !== want.result_kind)
        report("result_kind", 16'(got.result_kind), 16'(want.result_kind));
      if (got.out_number !== want.out_number) report("out_number", got.out_number, want.out_number);
      if (got.out_type !== want.out_type) report("out_type", 16'(got.out_type), 16'(want.out_type));
      if (got.out_tag !== want.out_tag) report("out_tag", got.out_tag, want.out_tag);
      if (got.last !== want.last) report("last", 16'(got.last), 16'(want.last));
    end
  endtask

  // Presents one item from a falling edge and returns at a falling edge after it is taken.
  // start is left high so the next item can follow back to back, unless idle_pct drops it for a gap.
  task automatic send_packet(input packet_t p, input bit typed, input result_t tr);
    packet    = p;
    start     = 1'b1;
    typed_row = typed;
    typed_res = tr;
    @(posedge clk);
    while (busy) @(posedge clk);
    n_sent++;
    @(negedge clk);
    if ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
  endtask

  task automatic write_window(input logic [4:0] v);
    start = 1'b0;
    while (pending_results.size() != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wdata = v;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  function automatic packet_t noise_packet();
    packet_t p;
    int w;
    w = eff_window(win_reg);
    case ($urandom_range(3))
      0: p.seq_number = 16'($urandom);
      1: p.seq_number = SEQ_MOD;
      2: p.seq_number = 16'((int'(exp_num) + int'(SEQ_MOD) - $urandom_range(1, 20)) % int'(SEQ_MOD));
      default: p.seq_number = 16'((int'(exp_num) + w + $urandom_range(0, 3)) % int'(SEQ_MOD));
    endcase
    p.msg_type    = 1'($urandom);
    p.payload_tag = 16'($urandom);
    return p;
  endfunction

  // Prediction happens at the edge that accepts an item; results are checked as they appear.
  // A result that nothing predicted does not count as progress.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (cfg_we) win_reg = cfg_wdata;
      if (start && !busy) begin
        quiet_cycles = 0;
        reorder_receive(packet);
        if (typed_row) pending_results.push_back(typed_res);
        else for (int k = 0; k < batch_n; k++) pending_results.push_back(batch[k]);
      end
      if (strobe) begin
        if (pending_results.size() != 0) quiet_cycles = 0;
        check_result(result);
      end
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("simulation failed");
    $finish;
  end

  initial begin
    result_t tr;
    packet_t p;
    int order [WIN_MAX];
    int n;
    int w;
    int j;
    int tmp;
    bit drop_head;
    logic [15:0] base;
    logic [4:0] v;

    // Window 10 after reset, expected number 0.
    directed[0]  = pkt_row(16'hFFFF, 1'b1, 16'hFFFF, 1'b1, KIND_REJECT, 16'd0);
    directed[1]  = pkt_row(16'd5, 1'b1, 16'hFFFF, 1'b1, KIND_ACK, 16'd5);
    directed[2]  = pkt_row(16'd5, 1'b0, 16'h1234, 1'b1, KIND_ACK, 16'd5);
    directed[3]  = pkt_row(16'd9, 1'b0, 16'h0001, 1'b1, KIND_ACK, 16'd9);
    directed[4]  = pkt_row(16'd10, 1'b1, 16'h8000, 1'b1, KIND_REJECT, 16'd0);
    directed[5]  = pkt_row(16'd65534, 1'b0, 16'h00FF, 1'b1, KIND_DUP, 16'd65534);
    directed[6]  = pkt_row(16'd65525, 1'b1, 16'hFF00, 1'b1, KIND_DUP, 16'd65525);
    directed[7]  = pkt_row(16'd65524, 1'b0, 16'h0000, 1'b1, KIND_REJECT, 16'd0);
    directed[8]  = pkt_row(16'd3, 1'b1, 16'hBEEF, 1'b1, KIND_ACK, 16'd3);
    directed[9]  = pkt_row(16'd0, 1'b0, 16'h0000, 1'b0, KIND_ACK, 16'd0);
    directed[10] = pkt_row(16'd2, 1'b0, 16'h7777, 1'b1, KIND_ACK, 16'd2);
    directed[11] = pkt_row(16'd1, 1'b1, 16'hAAAA, 1'b0, KIND_ACK, 16'd0);
    directed[12] = pkt_row(16'd4, 1'b1, 16'h5555, 1'b0, KIND_ACK, 16'd0);
    directed[13] = cfg_row(5'd0);
    directed[14] = pkt_row(16'd7, 1'b0, 16'h1111, 1'b1, KIND_REJECT, 16'd0);
    directed[15] = pkt_row(16'd5, 1'b0, 16'h2222, 1'b1, KIND_DUP, 16'd5);
    directed[16] = pkt_row(16'd4, 1'b1, 16'h3333, 1'b1, KIND_REJECT, 16'd0);
    directed[17] = pkt_row(16'd6, 1'b1, 16'h4444, 1'b0, KIND_ACK, 16'd0);
    directed[18] = cfg_row(5'd31);
    directed[19] = pkt_row(16'd22, 1'b1, 16'hC3C3, 1'b1, KIND_ACK, 16'd22);
    directed[20] = pkt_row(16'd23, 1'b0, 16'h3C3C, 1'b1, KIND_REJECT, 16'd0);
    directed[21] = pkt_row(16'd8, 1'b0, 16'h0808, 1'b1, KIND_ACK, 16'd8);
    // Shrinking the window leaves number 22 held beyond it.
    directed[22] = cfg_row(5'd1);
    directed[23] = pkt_row(16'd7, 1'b1, 16'h0707, 1'b0, KIND_ACK, 16'd0);
    directed[24] = cfg_row(5'd16);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < 25; i++) begin
      if (directed[i].is_cfg) begin
        write_window(directed[i].win);
      end else begin
        tr = mk_result(directed[i].kind, directed[i].num, 1'b0, 16'd0);
        tr.last = 1'b1;
        send_packet(directed[i].pkt, directed[i].typed, tr);
      end
    end

    tr = '0;
    while (n_sent < ITEM_TARGET) begin
      idle_pct = (n_sent >= 150 && n_sent < 240) ? 0 : 12;
      if ($urandom_range(5) == 0) begin
        case ($urandom_range(4))
          0: v = 5'd0;
          1: v = 5'd1;
          2: v = 5'd16;
          3: v = 5'd31;
          default: v = 5'($urandom_range(2, 15));
        endcase
        write_window(v);
      end
      if ($urandom_range(3) == 0) begin
        send_packet(noise_packet(), 1'b0, tr);
      end else begin
        // A burst covers the whole window, at times without the expected number, in random or
        // descending order, the latter filling every slot before the expected number arrives.
        w = eff_window(win_reg);
        n = w;
        base = exp_num;
        drop_head = ($urandom_range(4) == 0);
        for (j = 0; j < n; j++) order[j] = j;
        if ($urandom_range(3) == 0) begin
          for (j = 0; j < n; j++) order[j] = n - 1 - j;
        end else begin
          for (j = n - 1; j > 0; j--) begin
            tmp = $urandom_range(j);
            {order[j], order[tmp]} = {order[tmp], order[j]};
          end
        end
        for (j = 0; j < n; j++) begin
          if (drop_head && order[j] == 0) continue;
          p.seq_number  = 16'((int'(base) + order[j]) % int'(SEQ_MOD));
          p.msg_type    = 1'($urandom);
          p.payload_tag = 16'($urandom);
          send_packet(p, 1'b0, tr);
          if ($urandom_range(9) == 0) begin
            p.payload_tag = 16'($urandom);
            send_packet(p, 1'b0, tr);
          end else if ($urandom_range(14) == 0) begin
            send_packet(noise_packet(), 1'b0, tr);
          end
        end
      end
    end
    start = 1'b0;

    while (pending_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
